>>> src/nal_start_code_splitter_core_macros.svh
// Assertion macros used by the splitter core.
`ifndef NAL_START_CODE_SPLITTER_CORE_MACROS_SVH
`define NAL_START_CODE_SPLITTER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NSCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NSCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/nscs_pkg.sv
`default_nettype none

package nscs_pkg;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int SIZE_W = 24;
    localparam int TYPE_W = 5;

    // Default width of the unit byte counter.
    localparam int COUNT_BITS_DEF = 24;

    // Start code 00 00 00 01: three zero bytes of history, then a one.
    localparam logic [3*BYTE_W-1:0] SC_PREFIX = '0;
    localparam logic [BYTE_W-1:0]   SC_LAST   = 8'h01;

    // The unit type sits in the low five bits of the fifth byte.
    localparam logic [BYTE_W-1:0] TYPE_MASK = 8'h1F;

    // Byte offset of the fifth byte, and the count at which the last byte
    // of a start code found four or more bytes into the unit arrives.
    localparam int TYPE_POS   = 4;
    localparam int SC_END_POS = 7;

    // Largest reportable size.
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    // One finished unit.
    typedef struct packed {
        logic [SIZE_W-1:0] unit_size;
        logic [TYPE_W-1:0] unit_type;
        logic              size_saturated;
    } nscs_result_t;

endpackage

`default_nettype wire

>>> src/nscs_in_if.sv
`default_nettype none

interface nscs_in_if;

    logic                      valid;
    logic                      ready;
    logic [nscs_pkg::BYTE_W-1:0] data_byte;
    logic                      end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);

endinterface

`default_nettype wire

>>> src/nscs_out_if.sv
`default_nettype none

interface nscs_out_if;

    logic                        valid;
    logic                        ready;
    logic [nscs_pkg::SIZE_W-1:0] unit_size;
    logic [nscs_pkg::TYPE_W-1:0] unit_type;
    logic                        size_saturated;

    modport source (output valid, output unit_size, output unit_type,
                    output size_saturated, input ready);
    modport sink   (input valid, input unit_size, input unit_type,
                    input size_saturated, output ready);

endinterface

`default_nettype wire

>>> src/nal_start_code_splitter_core.sv
// A start code's last byte is registered at the input, its result word at the output.
// Throughput: one byte per cycle; the input register feeds the tracker and a
// single output register, so a byte stalls only when a result finds that register full.
// Reset: rst_n is asynchronous and active low; it empties both registers and
// clears the byte history, the unit count, the captured type and the overflow flag.
`default_nettype none

module nal_start_code_splitter_core #(
    parameter int COUNT_BITS = nscs_pkg::COUNT_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    nscs_in_if.sink    in_ch,
    nscs_out_if.source out_ch
);

    import nscs_pkg::*;
    `include "nal_start_code_splitter_core_macros.svh"

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eos_reg;

    logic         hit;
    logic         out_free;
    logic         advance;
    nscs_result_t result;

    // A held word moves on unless it produces a result and the output slot is full.
    assign advance     = in_valid_reg && (!hit || out_free);
    assign in_ch.ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_byte_reg <= in_ch.data_byte;
            in_eos_reg  <= in_ch.end_of_stream;
        end
    end

    // Start code tracking and size calculation.
    nscs_parse #(
        .COUNT_BITS(COUNT_BITS)
    ) u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (in_byte_reg),
        .end_of_stream (in_eos_reg),
        .commit        (advance),
        .hit           (hit),
        .result        (result)
    );

    // Result register.
    nscs_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance && hit),
        .result (result),
        .free   (out_free),
        .out_ch (out_ch)
    );

    // A unit always spans at least its own start code.
    `NSCS_ASSERT_NOW(a_size_min, out_ch.valid, out_ch.unit_size >= SIZE_W'(4), "unit size below four")
    // A saturated size reads as the field maximum.
    `NSCS_ASSERT_NOW(a_sat_max, out_ch.valid && out_ch.size_saturated, out_ch.unit_size == SIZE_MAX, "saturated size not at maximum")
    // A held byte that cannot move on stays in the input register.
    `NSCS_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance, in_valid_reg, "stalled input word lost")
    // An end-of-stream word never yields a result.
    `NSCS_ASSERT_NOW(a_eos_silent, in_valid_reg && in_eos_reg, !hit, "result raised on end of stream")

endmodule

`default_nettype wire

>>> src/nscs_parse.sv
`default_nettype none

module nscs_parse #(
    parameter int COUNT_BITS = nscs_pkg::COUNT_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [nscs_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                        end_of_stream,
    input  wire logic                        commit,
    output      logic                        hit,
    output      nscs_pkg::nscs_result_t      result
);

    import nscs_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [3*BYTE_W-1:0]   recent_reg, recent_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [TYPE_W-1:0]     type_reg, type_next;
    logic                  ovf_reg, ovf_next;

    logic [COUNT_BITS-1:0] size_full;
    logic                  size_wide;

    // Start code detection: the last byte of 00 00 00 01 found at least
    // four bytes into the current unit, or in a unit that overflowed.
    assign hit = !end_of_stream && (recent_reg == SC_PREFIX) && (data_byte == SC_LAST)
                 && (ovf_reg || (count_reg >= COUNT_BITS'(SC_END_POS)));

    // The unit ends three bytes before the count, i.e. before the new start code.
    assign size_full = count_reg - COUNT_BITS'(3);
    assign size_wide = (size_full >> SIZE_W) != '0;

    // Result of the finished unit.
    always_comb
    begin
        result.unit_type = type_reg;
        if (ovf_reg || size_wide)
        begin
            result.unit_size      = SIZE_MAX;
            result.size_saturated = 1'b1;
        end
        else
        begin
            result.unit_size      = SIZE_W'(size_full);
            result.size_saturated = 1'b0;
        end
    end

    // Next state of the unit tracker.
    always_comb
    begin
        recent_next = {recent_reg[2*BYTE_W-1:0], data_byte};
        count_next  = count_reg;
        type_next   = type_reg;
        ovf_next    = ovf_reg;
        priority if (end_of_stream)
        begin
            recent_next = '0;
            count_next  = '0;
            type_next   = '0;
            ovf_next    = 1'b0;
        end
        else if (hit)
        begin
            // The start code just seen opens the next unit.
            count_next = COUNT_BITS'(4);
            type_next  = '0;
            ovf_next   = 1'b0;
        end
        else
        begin
            if ((count_reg == COUNT_BITS'(TYPE_POS)) && !ovf_reg)
            begin
                type_next = TYPE_W'(data_byte & TYPE_MASK);
            end
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // State registers, updated only when the word moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= '0;
            count_reg  <= '0;
            type_reg   <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (commit)
        begin
            recent_reg <= recent_next;
            count_reg  <= count_next;
            type_reg   <= type_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

`default_nettype wire

>>> src/nscs_out_reg.sv
`default_nettype none

module nscs_out_reg (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire nscs_pkg::nscs_result_t result,
    output      logic                   free,
    nscs_out_if.source                  out_ch
);

    import nscs_pkg::*;

    logic         valid_reg;
    nscs_result_t data_reg;

    // The slot can take a new word when empty or when its word leaves now.
    assign free = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            data_reg <= result;
        end
    end

    assign out_ch.valid          = valid_reg;
    assign out_ch.unit_size      = data_reg.unit_size;
    assign out_ch.unit_type      = data_reg.unit_type;
    assign out_ch.size_saturated = data_reg.size_saturated;

endmodule

`default_nettype wire
